// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// shared widths, codes, character classes and stage types of the parser
// ----------------------------------------------------------------------------
package isp_pkg;

  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 64;
  localparam int POS_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int RADIX_W   = 6;
  localparam int PROD_W    = VALUE_W + RADIX_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0] MAX_STRING_LEN = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [VALUE_W-1:0] LIMIT_RESET = '1;

  localparam logic [RADIX_W-1:0] BASE_DETECT = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
  localparam logic [CHAR_W-1:0] DIG_NONE  = 8'hFF;
  localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'd10;

  typedef enum logic [1:0] {
    EK_NONE        = 2'd0,
    EK_INVALID     = 2'd1,
    EK_BARE_PREFIX = 2'd3
  } err_kind_t;

  typedef struct packed {
    err_kind_t          err;
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic               ovf;
    logic [POS_W-1:0]   end_pos;
  } snap_t;

  function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
    else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + ALPHA_OFS;
    else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + ALPHA_OFS;
    else d = DIG_NONE;
    return d;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ===== rtl/core/isp_scan.sv =====
// ----------------------------------------------------------------------------
// isp_scan
// input register and per-character scan: white space, sign, prefix, digits
// ----------------------------------------------------------------------------
module isp_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [isp_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                          in_end_of_string,
  input  logic [isp_pkg::RADIX_W-1:0]   radix,
  output logic                          snap_valid,
  input  logic                          snap_ready,
  output isp_pkg::snap_t                snap
);
  import isp_pkg::*;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_X      = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  logic                 in_v_r;
  logic [CHAR_W-1:0]    char_r;
  logic                 eos_r;

  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [RADIX_W-1:0]   base_r, base_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     endp_r, endp_nxt;
  err_kind_t            err_r, err_nxt;

  logic                 snap_v_r;
  snap_t                snap_r;

  logic                 consume;
  logic [CHAR_W-1:0]    c;
  logic [CHAR_W-1:0]    dig;
  logic                 fc;
  logic [RADIX_W-1:0]   fb;
  logic                 do_step;
  logic [RADIX_W-1:0]   sb;
  logic                 bump;
  logic [PROD_W-1:0]    prod;

  assign consume  = in_v_r && (!eos_r || !snap_v_r || snap_ready);
  assign in_stall = in_v_r && !consume;

  always_comb begin
    c   = eos_r ? CH_NUL : char_r;
    dig = digit_of(c);
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    ovf_nxt   = ovf_r;
    pos_nxt   = pos_r;
    endp_nxt  = endp_r;
    err_nxt   = err_r;
    fc        = 1'b0;
    fb        = base_r;
    do_step   = 1'b0;
    sb        = base_r;
    bump      = 1'b0;
    unique case (phase_r)
      PH_SPACE: begin
        base_nxt = radix;
        if (radix > BASE_MAX || radix == BASE_ONE) begin
          phase_nxt = PH_DONE;
          endp_nxt  = '0;
          err_nxt   = EK_INVALID;
        end else if (is_space(c)) begin
          bump = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_nxt   = (c == CH_MINUS);
          bump      = 1'b1;
          phase_nxt = PH_SIGN;
        end else begin
          fc = 1'b1;
          fb = radix;
        end
      end
      PH_SIGN: begin
        fc = 1'b1;
      end
      PH_ZERO: begin
        if ((c | CASE_BIT) == CH_LX) begin
          bump      = 1'b1;
          phase_nxt = PH_X;
        end else begin
          sb        = (base_r == BASE_DETECT) ? BASE_OCT : base_r;
          base_nxt  = sb;
          phase_nxt = PH_DIGITS;
          do_step   = 1'b1;
        end
      end
      PH_X: begin
        if (dig >= CHAR_W'(BASE_HEX)) begin
          phase_nxt = PH_DONE;
          endp_nxt  = (pos_r != '0) ? pos_r - 1'b1 : '0;
          err_nxt   = EK_BARE_PREFIX;
        end else begin
          sb        = BASE_HEX;
          base_nxt  = BASE_HEX;
          phase_nxt = PH_DIGITS;
          do_step   = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_step = 1'b1;
      end
      default: begin
      end
    endcase

    // first character after white space and sign
    if (fc) begin
      if ((fb == BASE_DETECT || fb == BASE_HEX) && c == CH_ZERO) begin
        bump      = 1'b1;
        phase_nxt = PH_ZERO;
        base_nxt  = fb;
      end else begin
        sb       = (fb == BASE_DETECT) ? BASE_DEC : fb;
        base_nxt = sb;
        if (dig >= CHAR_W'(sb)) begin
          phase_nxt = PH_DONE;
          endp_nxt  = '0;
          err_nxt   = EK_INVALID;
        end else begin
          phase_nxt = PH_DIGITS;
          do_step   = 1'b1;
        end
      end
    end

    prod = PROD_W'(acc_r) * PROD_W'(sb) + PROD_W'(dig);

    if (do_step) begin
      if (dig >= CHAR_W'(sb) || sb == BASE_DETECT) begin
        phase_nxt = PH_DONE;
        endp_nxt  = pos_r;
        err_nxt   = EK_NONE;
      end else begin
        if (!ovf_r) begin
          if (|prod[PROD_W-1:VALUE_W]) ovf_nxt = 1'b1;
          else acc_nxt = prod[VALUE_W-1:0];
        end
        bump = 1'b1;
      end
    end

    if (bump && pos_r < MAX_STRING_LEN) pos_nxt = pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      phase_r  <= PH_SPACE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      base_r   <= '0;
      ovf_r    <= 1'b0;
      pos_r    <= '0;
      endp_r   <= '0;
      err_r    <= EK_NONE;
      snap_v_r <= 1'b0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (snap_ready) snap_v_r <= 1'b0;
      if (consume) begin
        if (eos_r) begin
          snap_v_r <= 1'b1;
          phase_r  <= PH_SPACE;
          neg_r    <= 1'b0;
          acc_r    <= '0;
          base_r   <= '0;
          ovf_r    <= 1'b0;
          pos_r    <= '0;
          endp_r   <= '0;
          err_r    <= EK_NONE;
        end else begin
          phase_r  <= phase_nxt;
          neg_r    <= neg_nxt;
          acc_r    <= acc_nxt;
          base_r   <= base_nxt;
          ovf_r    <= ovf_nxt;
          pos_r    <= pos_nxt;
          endp_r   <= endp_nxt;
          err_r    <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_code;
      eos_r  <= in_end_of_string;
    end
    if (consume && eos_r) begin
      snap_r.err     <= err_nxt;
      snap_r.acc     <= acc_nxt;
      snap_r.neg     <= neg_nxt;
      snap_r.ovf     <= ovf_nxt;
      snap_r.end_pos <= endp_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

// ===== rtl/core/isp_final.sv =====
// ----------------------------------------------------------------------------
// isp_final
// limit rules, sign and status for a finished string, result register
// ----------------------------------------------------------------------------
module isp_final (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          snap_valid,
  output logic                          snap_ready,
  input  isp_pkg::snap_t                snap,
  input  logic [isp_pkg::VALUE_W-1:0]   limit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [isp_pkg::VALUE_W-1:0]   out_value,
  output logic [isp_pkg::POS_W-1:0]     out_consumed,
  output logic [isp_pkg::STATUS_W-1:0]  out_status
);
  import isp_pkg::*;

  logic                 out_v_r;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [POS_W-1:0]     cons_r, cons_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic [VALUE_W-1:0]   y;
  logic                 neg;

  assign snap_ready = !out_v_r || !out_stall;

  always_comb begin
    y          = snap.ovf ? limit : snap.acc;
    neg        = snap.neg && !(snap.ovf && limit[0]);
    value_nxt  = '0;
    cons_nxt   = snap.end_pos;
    status_nxt = snap.ovf ? ST_RANGE : ST_OK;
    if (snap.err == EK_INVALID) begin
      cons_nxt   = '0;
      status_nxt = ST_INVALID;
    end else if (snap.err == EK_BARE_PREFIX) begin
      status_nxt = ST_OK;
    end else if (y >= limit && !limit[0] && !neg) begin
      value_nxt  = limit - 1'b1;
      status_nxt = ST_RANGE;
    end else if (y > limit) begin
      value_nxt  = limit;
      status_nxt = ST_RANGE;
    end else begin
      value_nxt = neg ? '0 - y : y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (snap_ready) begin
      out_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      value_r  <= value_nxt;
      cons_r   <= cons_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_value    = value_r;
  assign out_consumed = cons_r;
  assign out_status   = status_r;

endmodule

// ===== rtl/core/integer_string_parser_top.sv =====
// ----------------------------------------------------------------------------
// integer_string_parser_top
// streaming integer parser: one character per transfer, one result per string
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  in_     | input     | char_code, end_of_string         | valid / stall
//  out_    | output    | value, consumed, status          | valid / stall
//  cfg_    | input     | index, wdata (radix, limit)      | wr_en
//
//  one character per cycle while in_stall is low, set by the scan stage's 64x6 multiply-add
//  a result is registered after its end marker transfer in the input register,
//  then the scan register, then the result register
//  reset (synchronous, rst_n low) empties all stages and loads radix 10 and
//  an all-ones limit; out_stall backs up through the stages into in_stall
// ----------------------------------------------------------------------------
module integer_string_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [isp_pkg::CHAR_W-1:0]      in_char_code,
  input  logic                            in_end_of_string,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [isp_pkg::VALUE_W-1:0]     out_value,
  output logic [isp_pkg::POS_W-1:0]       out_consumed,
  output logic [isp_pkg::STATUS_W-1:0]    out_status,
  input  logic                            cfg_wr_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isp_pkg::VALUE_W-1:0]     cfg_wdata
);
  import isp_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [VALUE_W-1:0] limit_r;

  logic               snap_valid;
  logic               snap_ready;
  snap_t              snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIX: radix_r <= cfg_wdata[RADIX_W-1:0];
        CFG_LIMIT: limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  isp_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .radix            (radix_r),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap)
  );

  isp_final u_final (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .limit        (limit_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .out_status   (out_status)
  );

endmodule

// ===== rtl/core/isp_checker.sv =====
// ----------------------------------------------------------------------------
// isp_checker
// port-level checks on the integer parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_stall,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [isp_pkg::VALUE_W-1:0]     out_value,
  input  logic [isp_pkg::POS_W-1:0]       out_consumed,
  input  logic [isp_pkg::STATUS_W-1:0]    out_status
);
  import isp_pkg::*;

  // reset empties every stage
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_value) && $stable(out_consumed) && $stable(out_status))

  // an invalid string reports a zero value and nothing consumed
  `ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_valid && out_status == ST_INVALID,
    out_value == '0 && out_consumed == '0)

  // any other outcome has consumed at least one character
  `ASSERT_IMPLY(a_valid_consumed, clk, rst_n, out_valid && out_status != ST_INVALID,
    out_consumed != '0)

endmodule

bind integer_string_parser_top isp_checker u_isp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_value    (out_value),
  .out_consumed (out_consumed),
  .out_status   (out_status)
);

// ===== tb/integer_string_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// integer_string_parser_top_tb
// self-checking bench for the streaming integer string parser: directed
// strings for prefixes, signs, bad bases, overflow, limit rules and a long
// run of leading white space, then random strings under random radix and
// limit settings, with random idle cycles on both channels; every result
// transfer is checked against a cycle-free scan model kept in the bench
// ----------------------------------------------------------------------------
module integer_string_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isp_pkg::*;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t text_t[$];

  typedef enum logic [2:0] {
    SCAN_SPACE, SCAN_SIGN, SCAN_ZERO, SCAN_X, SCAN_DIGITS, SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    consumed;
    logic [STATUS_W-1:0] status;
  } parse_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  char_t                in_char_code = '0;
  logic                 in_end_of_string = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_value;
  logic [POS_W-1:0]     out_consumed;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIX;
  logic [VALUE_W-1:0]   cfg_wdata = '0;

  // scan model state
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  logic [VALUE_W-1:0] limit_reg = LIMIT_RESET;
  scan_phase_t        scan_phase = SCAN_SPACE;
  logic               minus_seen = 1'b0;
  logic [VALUE_W-1:0] acc = '0;
  logic [RADIX_W-1:0] base = '0;
  logic               acc_ovf = 1'b0;
  logic [POS_W-1:0]   char_pos = '0;
  logic [POS_W-1:0]   stop_pos = '0;
  err_kind_t          stop_kind = EK_NONE;

  parse_result_t expected_q[$];

  int fail_count = 0;
  int strings_done = 0;
  int chars_sent = 0;
  int settings_used = 0;
  int in_gap_max = 6;
  int out_gap_max = 6;

  always #5 clk = ~clk;

  integer_string_parser_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_consumed     (out_consumed),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic int digit_value(input char_t c);
    char_t low;
    low = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (low >= CH_LA && low <= CH_LZ) return int'(low - CH_LA) + 10;
    return 255;
  endfunction

  function automatic char_t digit_char(input int d);
    if (d < 10) return char_t'(CH_ZERO + d);
    return char_t'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10);
  endfunction

  task automatic clear_scan();
    scan_phase = SCAN_SPACE;
    minus_seen = 1'b0;
    acc = '0;
    base = '0;
    acc_ovf = 1'b0;
    char_pos = '0;
    stop_pos = '0;
    stop_kind = EK_NONE;
  endtask

  task automatic advance();
    if (char_pos != MAX_STRING_LEN) char_pos = char_pos + 1'b1;
  endtask

  task automatic end_scan(input logic [POS_W-1:0] p, input err_kind_t k);
    stop_pos = p;
    stop_kind = k;
    scan_phase = SCAN_DONE;
  endtask

  task automatic add_digit(input char_t c);
    int d;
    logic [VALUE_W-1:0] dv;
    logic [VALUE_W-1:0] bv;
    d = digit_value(c);
    if (d >= base || base == '0) begin
      end_scan(char_pos, EK_NONE);
    end else begin
      dv = VALUE_W'(d);
      bv = VALUE_W'(base);
      if (!acc_ovf) begin
        if (acc > ({VALUE_W{1'b1}} - dv) / bv) acc_ovf = 1'b1;
        else acc = acc * bv + dv;
      end
      advance();
    end
  endtask

  task automatic lead_char(input char_t c);
    if ((base == BASE_DETECT || base == BASE_HEX) && c == CH_ZERO) begin
      advance();
      scan_phase = SCAN_ZERO;
    end else begin
      if (base == BASE_DETECT) base = BASE_DEC;
      if (digit_value(c) >= base) begin
        end_scan('0, EK_INVALID);
      end else begin
        scan_phase = SCAN_DIGITS;
        add_digit(c);
      end
    end
  endtask

  task automatic scan_char(input char_t c);
    case (scan_phase)
      SCAN_SPACE: begin
        base = radix_reg;
        if (base > BASE_MAX || base == BASE_ONE) begin
          end_scan('0, EK_INVALID);
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          advance();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          minus_seen = (c == CH_MINUS);
          advance();
          scan_phase = SCAN_SIGN;
        end else begin
          lead_char(c);
        end
      end
      SCAN_SIGN: lead_char(c);
      SCAN_ZERO: begin
        if ((c | CASE_BIT) == CH_LX) begin
          advance();
          scan_phase = SCAN_X;
        end else begin
          if (base == BASE_DETECT) base = BASE_OCT;
          scan_phase = SCAN_DIGITS;
          add_digit(c);
        end
      end
      SCAN_X: begin
        if (digit_value(c) >= BASE_HEX) begin
          end_scan((char_pos != '0) ? char_pos - 1'b1 : '0, EK_BARE_PREFIX);
        end else begin
          base = BASE_HEX;
          scan_phase = SCAN_DIGITS;
          add_digit(c);
        end
      end
      SCAN_DIGITS: add_digit(c);
      default: ;
    endcase
  endtask

  task automatic take_item(input char_t c, input logic eos);
    parse_result_t r;
    logic [VALUE_W-1:0] y;
    logic neg;
    if (!eos) begin
      scan_char(c);
    end else begin
      scan_char(CH_NUL);
      r.value = '0;
      r.consumed = stop_pos;
      r.status = ST_OK;
      if (stop_kind == EK_INVALID) begin
        r.consumed = '0;
        r.status = ST_INVALID;
      end else if (stop_kind == EK_NONE) begin
        y = acc;
        neg = minus_seen;
        if (acc_ovf) begin
          y = limit_reg;
          r.status = ST_RANGE;
          if (limit_reg[0]) neg = 1'b0;
        end
        if (y >= limit_reg && !limit_reg[0] && !neg) begin
          r.value = limit_reg - 1'b1;
          r.status = ST_RANGE;
        end else if (y > limit_reg) begin
          r.value = limit_reg;
          r.status = ST_RANGE;
        end else begin
          r.value = neg ? -y : y;
        end
      end
      expected_q.push_back(r);
      clear_scan();
    end
  endtask

  // follow every register write and input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      radix_reg = RADIX_RESET;
      limit_reg = LIMIT_RESET;
      clear_scan();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_RADIX) radix_reg = cfg_wdata[RADIX_W-1:0];
        else if (cfg_index == CFG_LIMIT) limit_reg = cfg_wdata;
      end
      if (in_valid && !in_stall) take_item(in_char_code, in_end_of_string);
    end
  end

  always @(posedge clk) begin : check_result
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: value %h consumed %0d status %0d",
               out_value, out_consumed, out_status);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        strings_done++;
        if (out_value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_value);
          fail_count++;
        end
        if (out_consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, out_consumed);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin : out_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (rst_n && ((out_valid && !out_stall) ||
                    (!out_valid && $urandom_range(0, 7) == 0))) begin
        n = $urandom_range(0, out_gap_max);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(input char_t c, input logic eos);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_item(t[i], 1'b0);
    send_item(char_t'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [RADIX_W-1:0] r, input logic [VALUE_W-1:0] lim);
    logic [VALUE_W-1:0] word;
    wait_idle();
    word = {$urandom, $urandom};
    word[RADIX_W-1:0] = r;
    write_reg(CFG_RADIX, word);
    write_reg(CFG_LIMIT, lim);
    settings_used++;
  endtask

  function automatic text_t render_value(input logic [VALUE_W-1:0] v, input int b);
    text_t t;
    if (v == '0) t.push_back(CH_ZERO);
    while (v != '0) begin
      t.push_front(digit_char(int'(v % VALUE_W'(b))));
      v = v / VALUE_W'(b);
    end
    return t;
  endfunction

  function automatic text_t random_text(input logic [RADIX_W-1:0] r);
    text_t t;
    text_t digits;
    int kind;
    int n;
    int b;
    kind = $urandom_range(0, 9);
    if (kind >= 8 || r > BASE_MAX || r == BASE_ONE) begin
      n = $urandom_range(0, 10);
      repeat (n) t.push_back(char_t'($urandom_range(0, 255)));
      return t;
    end
    repeat ($urandom_range(0, 3)) begin
      n = $urandom_range(0, 5);
      t.push_back((n == 0) ? CH_SPACE : char_t'(CH_TAB + n - 1));
    end
    case ($urandom_range(0, 2))
      1: t.push_back(CH_PLUS);
      2: t.push_back(CH_MINUS);
      default: ;
    endcase
    // broken sequences: sign or space only, bare prefix, or a stray byte
    if (kind == 7) begin
      case ($urandom_range(0, 2))
        0: ;
        1: begin
          t.push_back(CH_ZERO);
          t.push_back($urandom_range(0, 1) ? CH_LX : CH_LX & ~CASE_BIT);
        end
        default: t.push_back(char_t'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1)) t.push_back(char_t'($urandom_range(0, 255)));
      return t;
    end
    b = int'(r);
    if (r == BASE_DETECT) begin
      case ($urandom_range(0, 2))
        0: b = int'(BASE_DEC);
        1: begin
          b = int'(BASE_OCT);
          t.push_back(CH_ZERO);
        end
        default: begin
          b = int'(BASE_HEX);
          t.push_back(CH_ZERO);
          t.push_back($urandom_range(0, 1) ? CH_LX : CH_LX & ~CASE_BIT);
        end
      endcase
    end else if (r == BASE_HEX && $urandom_range(0, 1)) begin
      t.push_back(CH_ZERO);
      t.push_back($urandom_range(0, 1) ? CH_LX : CH_LX & ~CASE_BIT);
    end
    if ($urandom_range(0, 9) == 0) begin
      // values around the saturation limit
      digits = render_value(limit_reg + $urandom_range(0, 2) - 1, b);
    end else begin
      case ($urandom_range(0, 9))
        7, 8:    n = $urandom_range(9, 22);
        9:       n = $urandom_range(23, 70);
        default: n = $urandom_range(1, 8);
      endcase
      repeat (n) digits.push_back(digit_char($urandom_range(0, b - 1)));
    end
    if (r == BASE_DETECT && b == BASE_DEC && digit_value(digits[0]) == 0)
      digits[0] = digit_char($urandom_range(1, 9));
    t = {t, digits};
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) t.push_back(char_t'($urandom_range(0, 255)));
    return t;
  endfunction

  task automatic test_reset_values();
    text_t t;
    send_text(to_text("-7"));
    t = to_text("12ab");
    t.push_back(8'hFF);
    t.push_back(8'h80);
    send_text(t);
  endtask

  task automatic test_prefix_detect();
    configure(BASE_DETECT, LIMIT_RESET);
    send_text(to_text(" -0x1F"));
    send_text(to_text("017"));
    send_text(to_text("0Xg"));
    send_text(to_text("09"));
  endtask

  task automatic test_no_digits();
    text_t t;
    configure(BASE_HEX, LIMIT_RESET);
    send_text(to_text(""));
    send_text(to_text("+z"));
    send_text(to_text("0x"));
    t = to_text("\t");
    t.push_back(CH_NUL);
    t.push_back(8'hFF);
    send_text(t);
  endtask

  task automatic test_invalid_base();
    configure(BASE_ONE, LIMIT_RESET);
    send_text(to_text("5"));
    configure('1, LIMIT_RESET);
    send_text(to_text("12"));
  endtask

  task automatic test_overflow_limits();
    configure(BASE_MAX, LIMIT_RESET);
    send_text(to_text("zzzzzzzzzzzzz"));
    configure(BASE_MAX, 64'h8000_0000_0000_0000);
    send_text(to_text("-zzzzzzzzzzzzz"));
    configure(BASE_HEX, 64'h8000_0000_0000_0000);
    send_text(to_text("8000000000000000"));
    send_text(to_text("-8000000000000000"));
    configure(BASE_DEC, '0);
    send_text(to_text("0"));
    configure(BASE_DEC, 64'd1);
    send_text(to_text("2"));
    send_text(to_text("-1"));
  endtask

  task automatic test_long_string();
    configure(BASE_DEC, LIMIT_RESET);
    in_gap_max = 0;
    repeat (60) send_item(CH_SPACE, 1'b0);
    send_text(to_text("-42"));
    in_gap_max = 6;
  endtask

  task automatic test_random();
    logic [RADIX_W-1:0] r;
    logic [VALUE_W-1:0] lim;
    int sent_start;
    for (int p = 0; p < 14; p++) begin
      case ($urandom_range(0, 9))
        0, 8: r = BASE_DETECT;
        1: r = RADIX_MIN;
        2: r = BASE_OCT;
        3: r = BASE_DEC;
        4: r = BASE_HEX;
        5: r = BASE_MAX;
        9: r = (p % 2) ? BASE_ONE : RADIX_W'($urandom_range(BASE_MAX + 1, 63));
        default: r = RADIX_W'($urandom_range(RADIX_MIN, BASE_MAX));
      endcase
      case ($urandom_range(0, 7))
        0: lim = '1;
        1: lim = '0;
        2: lim = 64'd1;
        3: lim = 64'h8000_0000_0000_0000;
        4: lim = 64'h7FFF_FFFF_FFFF_FFFF;
        5: lim = 64'hFFFF_FFFF_FFFF_FFFE;
        6: lim = 64'h0000_0000_FFFF_FFFF;
        default: lim = {$urandom, $urandom};
      endcase
      configure(r, lim);
      in_gap_max = (p % 4 == 3) ? 0 : 6;
      out_gap_max = (p % 5 == 4) ? 0 : 6;
      sent_start = chars_sent;
      while (chars_sent - sent_start < 60) send_text(random_text(r));
    end
    in_gap_max = 6;
    out_gap_max = 6;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_prefix_detect();
    test_no_digits();
    test_invalid_base();
    test_overflow_limits();
    test_long_string();
    test_random();
    in_valid <= 1'b0;
    for (int i = 0; i < 1000 && expected_q.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_count++;
    end
    $display("covered %0d strings in %0d character transfers over %0d register settings",
             strings_done, chars_sent, settings_used);
    $display("radix from detect to 36 plus invalid bases, limits from zero to all ones");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
